>>> rtl/core/brb_pkg.sv
// Shared types and constants for the byte ring buffer with peek and consume.
package brb_pkg;

    // Field widths fixed by the command and result formats
    localparam int DATA_W   = 64;
    localparam int LEN_W    = 7;
    localparam int OFF_W    = 12;
    localparam int CNT_W    = 7;
    localparam int NBYTES_W = 4;
    localparam int LEVEL_W  = 12;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_CONSUME = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_ROOM  = 2'd1,
        STAT_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_READ,
        S_EMIT_WORD,
        S_EMIT_ONE
    } state_t;

    typedef struct packed {
        cmd_code_t           cmd;
        logic [DATA_W-1:0]   push_data;
        logic [LEN_W-1:0]    length;
        logic [OFF_W-1:0]    offset;
        logic                want_data;
    } brb_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [CNT_W-1:0]    count;
        logic [DATA_W-1:0]   read_data;
        logic [NBYTES_W-1:0] read_bytes;
        logic                last;
        logic [LEVEL_W-1:0]  used_bytes;
        logic [LEVEL_W-1:0]  free_bytes;
    } brb_res_t;

endpackage

>>> rtl/core/brb_byte_ram.sv
// Single-port byte store with registered read data.
module brb_byte_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write or read one byte per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> rtl/core/brb_ctrl.sv
// Command sequencer: ring pointers, byte-serial push and read, result register.
module brb_ctrl #(
    parameter int MAX_REQ    = 64,
    parameter int LANE_BYTES = 8,
    parameter int AW         = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  brb_pkg::brb_cmd_t cmd_in,
    output logic              res_valid,
    input  logic              res_ready,
    output brb_pkg::brb_res_t res_out,
    output logic              ram_we,
    output logic              ram_re,
    output logic [AW-1:0]     ram_addr,
    output logic [7:0]        ram_wdata,
    input  logic [7:0]        ram_rdata
);

    import brb_pkg::*;

    localparam int CW  = ((AW > OFF_W) ? AW : OFF_W) + 1;
    localparam int LCW = $clog2(LANE_BYTES + 1);

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [AW-1:0]           addr_inc;
    logic [DATA_W-1:0]       push_data_reg, push_data_next;
    logic [LCW-1:0]          plen_reg, plen_next;
    logic [LCW-1:0]          lane_iss_reg, lane_iss_next;
    logic [LCW-1:0]          lane_cap_reg, lane_cap_next;
    logic                    pend_reg, pend_next;
    logic [DATA_W-1:0]       word_reg, word_next;
    logic [CNT_W-1:0]        remain_reg, remain_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    status_t                 status_reg, status_next;
    logic                    m_valid_reg, m_valid_next;
    brb_res_t                res_reg, res_next;

    logic [AW-1:0]           used_aw;
    logic [AW-1:0]           free_aw;
    logic [CW-1:0]           len_w;
    logic [CW-1:0]           len_sat;
    logic [CW-1:0]           off_w;
    logic [CW-1:0]           used_w;
    logic [CW-1:0]           diff_w;
    logic [CW-1:0]           n_w;
    logic [AW-1:0]           start_aw;
    logic [CNT_W-1:0]        chunk;
    logic                    slot_free;
    logic                    word_last;
    logic [7:0]              push_byte;

    // Shared address incrementer for push writes and reads
    assign addr_inc  = addr_reg + AW'(1);
    assign used_aw   = tail_reg - head_reg;
    assign free_aw   = head_reg - tail_reg - AW'(1);
    assign slot_free = !m_valid_reg || res_ready;
    assign chunk     = (remain_reg > CNT_W'(LANE_BYTES)) ? CNT_W'(LANE_BYTES) : remain_reg;
    assign word_last = (remain_reg == chunk);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = m_valid_reg;
    assign res_out   = res_reg;

    // Clip the read request against the fill level
    always_comb begin
        len_w   = CW'(cmd_in.length);
        len_sat = (len_w > CW'(MAX_REQ)) ? CW'(MAX_REQ) : len_w;
        off_w   = CW'(cmd_in.offset);
        used_w  = CW'(used_aw);
        diff_w  = used_w - off_w;
        if (cmd_in.cmd == CMD_PEEK) begin
            if (off_w >= used_w) begin
                n_w = '0;
            end else begin
                n_w = (diff_w > len_sat) ? len_sat : diff_w;
            end
            start_aw = head_reg + AW'(cmd_in.offset);
        end else begin
            n_w      = (used_w < len_sat) ? used_w : len_sat;
            start_aw = head_reg;
        end
    end

    // Pick the push byte for the current write step
    always_comb begin
        push_byte = '0;
        for (int l = 0; l < LANE_BYTES; l++) begin
            if (lane_iss_reg == LCW'(l)) begin
                push_byte = push_data_reg[8*l +: 8];
            end
        end
    end

    // Next state and datapath
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        addr_next      = addr_reg;
        push_data_next = push_data_reg;
        plen_next      = plen_reg;
        lane_iss_next  = lane_iss_reg;
        lane_cap_next  = lane_cap_reg;
        pend_next      = 1'b0;
        word_next      = word_reg;
        remain_next    = remain_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !res_ready;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = addr_reg;
        ram_wdata      = push_byte;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    status_next = STAT_OK;
                    count_next  = '0;
                    state_next  = S_EMIT_ONE;
                    unique case (cmd_in.cmd)
                        CMD_PUSH: begin
                            if (len_w > CW'(LANE_BYTES)) begin
                                status_next = STAT_TOO_LONG;
                            end else if (len_w > CW'(free_aw)) begin
                                status_next = STAT_NO_ROOM;
                            end else if (len_w != '0) begin
                                addr_next      = tail_reg;
                                push_data_next = cmd_in.push_data;
                                plen_next      = LCW'(cmd_in.length);
                                lane_iss_next  = '0;
                                state_next     = S_PUSH;
                            end
                        end
                        CMD_PEEK, CMD_CONSUME: begin
                            count_next = CNT_W'(n_w);
                            if (cmd_in.cmd == CMD_CONSUME) begin
                                head_next = head_reg + AW'(n_w);
                            end
                            if (cmd_in.want_data && (n_w != '0)) begin
                                remain_next   = CNT_W'(n_w);
                                addr_next     = start_aw;
                                lane_iss_next = '0;
                                lane_cap_next = '0;
                                word_next     = '0;
                                state_next    = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUSH: begin
                // Write one byte and advance the tail
                ram_we        = 1'b1;
                addr_next     = addr_inc;
                tail_next     = addr_inc;
                lane_iss_next = lane_iss_reg + LCW'(1);
                if (lane_iss_reg + LCW'(1) == plen_reg) begin
                    state_next = S_EMIT_ONE;
                end
            end
            S_READ: begin
                // Issue reads for the current word
                if (lane_iss_reg < LCW'(chunk)) begin
                    ram_re        = 1'b1;
                    addr_next     = addr_inc;
                    lane_iss_next = lane_iss_reg + LCW'(1);
                    pend_next     = 1'b1;
                end
                // Capture the byte read in the previous cycle
                if (pend_reg) begin
                    for (int l = 0; l < LANE_BYTES; l++) begin
                        if (lane_cap_reg == LCW'(l)) begin
                            word_next[8*l +: 8] = ram_rdata;
                        end
                    end
                    lane_cap_next = lane_cap_reg + LCW'(1);
                    if (lane_cap_reg + LCW'(1) == LCW'(chunk)) begin
                        state_next = S_EMIT_WORD;
                    end
                end
            end
            S_EMIT_WORD: begin
                if (slot_free) begin
                    m_valid_next        = 1'b1;
                    res_next.status     = STAT_OK;
                    res_next.count      = count_reg;
                    res_next.read_data  = word_reg;
                    res_next.read_bytes = NBYTES_W'(chunk);
                    res_next.last       = word_last;
                    res_next.used_bytes = LEVEL_W'(used_aw);
                    res_next.free_bytes = LEVEL_W'(free_aw);
                    remain_next         = remain_reg - chunk;
                    lane_iss_next       = '0;
                    lane_cap_next       = '0;
                    word_next           = '0;
                    state_next          = word_last ? S_IDLE : S_READ;
                end
            end
            S_EMIT_ONE: begin
                if (slot_free) begin
                    m_valid_next        = 1'b1;
                    res_next.status     = status_reg;
                    res_next.count      = count_reg;
                    res_next.read_data  = '0;
                    res_next.read_bytes = '0;
                    res_next.last       = 1'b1;
                    res_next.used_bytes = LEVEL_W'(used_aw);
                    res_next.free_bytes = LEVEL_W'(free_aw);
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        push_data_reg <= push_data_next;
        plen_reg      <= plen_next;
        lane_iss_reg  <= lane_iss_next;
        lane_cap_reg  <= lane_cap_next;
        word_reg      <= word_next;
        remain_reg    <= remain_next;
        count_reg     <= count_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
    end

endmodule

>>> rtl/core/byte_ring_buffer_peek_consume.sv
// Top level of the byte ring buffer with peek and consume.
//
// Commands arrive on the s_ stream: s_tuser carries the command code, s_tdata
// the push bytes, length, peek offset and want-data flag. Results leave on the
// m_ stream: m_tuser carries the status, m_tlast marks the final result of a
// command, m_tdata the count, read bytes, valid byte count and fill levels.
// A push of L bytes writes one byte per cycle, then its result is loaded into
// the output register once it is free, at once when nothing is written.
// A read of n bytes streams words of up to LANE_BYTES bytes. The single
// byte-wide store port paces pushes and reads: each byte of a word is read
// in turn, then the word is loaded into the output register. A new command is
// accepted once the last result of the previous one sits in the output
// register, so it overlaps a stalled receiver. While m_tready is low the
// output register holds its result and the sequencer waits before loading
// the next one. Reset empties the ring (head and tail at zero) and drops any
// pending result; the store itself needs no clearing pass.
module byte_ring_buffer_peek_consume #(
    parameter int DEPTH      = 4096,
    parameter int MAX_REQ    = 64,
    parameter int LANE_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // push_data[63:0], length[70:64], offset[82:71], want_data[83], zero pad
    input  logic [87:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // count[6:0], read_data[70:7], read_bytes[74:71], used_bytes[86:75],
    // free_bytes[98:87], zero pad
    output logic [103:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    brb_cmd_t      cmd;
    brb_res_t      res;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // Unpack the command transfer
    assign cmd.cmd       = cmd_code_t'(s_tuser);
    assign cmd.push_data = s_tdata[63:0];
    assign cmd.length    = s_tdata[70:64];
    assign cmd.offset    = s_tdata[82:71];
    assign cmd.want_data = s_tdata[83];

    brb_ctrl #(
        .MAX_REQ    (MAX_REQ),
        .LANE_BYTES (LANE_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_in    (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_out   (res),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    brb_byte_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Pack the result transfer
    assign m_tdata = {5'b0, res.free_bytes, res.used_bytes, res.read_bytes,
                      res.read_data, res.count};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

    // Fill levels always add up to the ring capacity
    a_level_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (12'(res.used_bytes + res.free_bytes) == 12'(DEPTH - 1)))
        else $error("used plus free bytes differ from ring capacity");

    // Rejected pushes report nothing read and close the command
    a_reject_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res.status != STAT_OK)) |-> (m_tlast && (res.count == '0)))
        else $error("rejected push result is not a single empty result");

    // Only the final word of a read may be partly filled
    a_full_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (res.read_bytes == 4'(LANE_BYTES)))
        else $error("non-final read word is not full");

    // A command transfer always leaves the sequencer busy in the cycle after it
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted back to back");

endmodule
